// ===== rtl/bhp_pkg.sv =====
// Shared types, constants and helper functions of the hybrid branch predictor.
// No dependencies; bhp_index, bhp_row_logic and the top level import this package.
`default_nettype none

package bhp_pkg;

  // Default sizes, handed to the top level parameters
  localparam int unsigned TableEntriesDef = 256;
  localparam int unsigned HistPatternsDef = 16;

  // Field widths of the stream beats
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 32;

  // Register reset and counter constants
  localparam logic [3:0]  TrainLimitRst = 4'd4;
  localparam logic [1:0]  CtrMax        = 2'd3;
  localparam logic [1:0]  CtrMin        = 2'd0;
  localparam logic [1:0]  BimodalRst    = 2'd1;
  localparam logic [1:0]  ChooserRst    = 2'd2;
  localparam logic [1:0]  PatternRst    = 2'd1;
  localparam logic [31:0] PcStep        = 32'd4;

  typedef enum logic {
    REQ_PREDICT = 1'b0,
    REQ_UPDATE  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    SRC_BIMODAL = 2'd0,
    SRC_LOCAL   = 2'd1,
    SRC_GLOBAL  = 2'd2
  } src_e;

  // One request as it moves down the pipeline
  typedef struct packed {
    req_e        req;
    logic [31:0] pc;
    logic        taken;
    logic        hit;
    logic [31:0] target;
  } item_t;

  // One prediction
  typedef struct packed {
    logic [31:0] next_pc;
    src_e        src;
  } pred_t;

  // Entry row: bimodal, chooser, training count, target, local history,
  // local pattern counters, global pattern counters
  function automatic int unsigned row_width(int unsigned hp);
    return 40 + $clog2(hp) + 4 * hp;
  endfunction

  // Two-bit saturating step
  function automatic logic [1:0] sat_step(logic [1:0] c, logic up);
    logic [1:0] r;
    if (up) begin
      r = (c == CtrMax) ? c : c + 2'd1;
    end else begin
      r = (c == CtrMin) ? c : c - 2'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bhp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read-first on an address collision. No dependencies.
`default_nettype none

module bhp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bhp_index.sv =====
// Entry index pipeline: (pc >> 2) modulo the table size over two stages.
// Masks for a power-of-two size, reciprocal multiply otherwise. Uses bhp_pkg.
`default_nettype none

module bhp_index import bhp_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  wire logic                            clk_i,
  input  wire logic [29:0]                     x_i,
  input  wire logic                            b_en_i,
  input  wire logic                            c_en_i,
  output logic      [$clog2(TableEntries)-1:0] id_o
);

  localparam int unsigned AW     = $clog2(TableEntries);
  localparam bit          IsPow2 = ((TableEntries & (TableEntries - 1)) == 0);

  if (IsPow2) begin : g_mask
    logic [AW-1:0] id_b_q, id_c_q;

    // Carry the low bits through both stages
    always_ff @(posedge clk_i) begin
      if (b_en_i) begin
        id_b_q <= x_i[AW-1:0];
      end
      if (c_en_i) begin
        id_c_q <= id_b_q;
      end
    end

    assign id_o = id_c_q;
  end else begin : g_recip
    localparam int unsigned RW    = $clog2(3 * TableEntries);
    localparam logic [29:0] Recip = 30'((64'd1 << 30) / 64'(TableEntries));
    localparam logic [RW-1:0] ModC = RW'(TableEntries);

    logic [59:0]   prod;
    logic [29:0]   q_b_q, x_b_q;
    logic [RW-1:0] r_c_d, r_c_q, r1, r2;

    // Quotient estimate, at most one below the true quotient
    assign prod = {30'd0, x_i} * {30'd0, Recip};

    // Remainder estimate, below twice the table size
    assign r_c_d = x_b_q[RW-1:0] - RW'(q_b_q) * ModC;

    always_ff @(posedge clk_i) begin
      if (b_en_i) begin
        q_b_q <= prod[59:30];
        x_b_q <= x_i;
      end
      if (c_en_i) begin
        r_c_q <= r_c_d;
      end
    end

    // Correct the remainder
    always_comb begin
      r1 = (r_c_q >= ModC) ? r_c_q - ModC : r_c_q;
      r2 = (r1 >= ModC) ? r1 - ModC : r1;
    end

    assign id_o = r2[AW-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/bhp_row_logic.sv =====
// Per-entry predict and update logic on one table row, plus the row's reset
// value for the clearing pass. Uses bhp_pkg.
`default_nettype none

module bhp_row_logic import bhp_pkg::*; #(
  parameter int unsigned HistPatterns = HistPatternsDef
) (
  input  wire logic [row_width(HistPatterns)-1:0] row_i,
  input  wire item_t                              item_i,
  input  wire logic [$clog2(HistPatterns)-1:0]    ghist_i,
  input  wire logic [3:0]                         limit_i,
  output logic      [row_width(HistPatterns)-1:0] row_o,
  output logic      [$clog2(HistPatterns)-1:0]    ghist_o,
  output pred_t                                   pred_o,
  output logic      [row_width(HistPatterns)-1:0] rst_row_o
);

  localparam int unsigned HB    = $clog2(HistPatterns);
  localparam int unsigned PW    = 2 * HistPatterns;
  localparam int unsigned BimLo = 0;
  localparam int unsigned ChoLo = 2;
  localparam int unsigned TrnLo = 4;
  localparam int unsigned TgtLo = 8;
  localparam int unsigned LhLo  = 40;
  localparam int unsigned LpLo  = LhLo + HB;
  localparam int unsigned GpLo  = LpLo + PW;
  localparam logic [HB:0] HistLimit = (HB + 1)'(HistPatterns);

  typedef logic [HistPatterns-1:0][1:0] pat_t;

  logic [1:0]    bim, cho, lc, gc, sel;
  logic [3:0]    trn;
  logic [31:0]   tgt;
  logic [HB-1:0] lh;
  pat_t          lpat, gpat, lpat_n, gpat_n, pat_rst;
  logic          training, use_local;

  // Shift the outcome into a history, wrapped to the pattern count
  function automatic logic [HB-1:0] shift_hist(logic [HB-1:0] h, logic t);
    logic [HB:0] v;
    v = {h, t};
    if (v >= HistLimit) begin
      v = v - HistLimit;
    end
    return v[HB-1:0];
  endfunction

  // Unpack the row
  always_comb begin
    bim       = row_i[BimLo +: 2];
    cho       = row_i[ChoLo +: 2];
    trn       = row_i[TrnLo +: 4];
    tgt       = row_i[TgtLo +: 32];
    lh        = row_i[LhLo +: HB];
    lpat      = row_i[LpLo +: PW];
    gpat      = row_i[GpLo +: PW];
    lc        = lpat[lh];
    gc        = gpat[ghist_i];
    training  = trn < limit_i;
    use_local = cho[1];
  end

  // Prediction
  always_comb begin
    if (training) begin
      sel        = bim;
      pred_o.src = SRC_BIMODAL;
    end else if (use_local) begin
      sel        = lc;
      pred_o.src = SRC_LOCAL;
    end else begin
      sel        = gc;
      pred_o.src = SRC_GLOBAL;
    end
    pred_o.next_pc = sel[1] ? tgt : item_i.pc + PcStep;
  end

  // Updated row under the old histories
  always_comb begin
    lpat_n     = lpat;
    gpat_n     = gpat;
    lpat_n[lh]      = sat_step(lc, item_i.taken);
    gpat_n[ghist_i] = sat_step(gc, item_i.taken);
    row_o      = row_i;
    if (training) begin
      row_o[BimLo +: 2] = sat_step(bim, item_i.taken);
      row_o[TrnLo +: 4] = trn + 4'd1;
    end else if (use_local) begin
      row_o[ChoLo +: 2] = sat_step(cho, item_i.hit);
    end else begin
      row_o[ChoLo +: 2] = sat_step(cho, !item_i.hit);
    end
    if (item_i.taken) begin
      row_o[TgtLo +: 32] = item_i.target;
    end
    row_o[LhLo +: HB] = shift_hist(lh, item_i.taken);
    row_o[LpLo +: PW] = lpat_n;
    row_o[GpLo +: PW] = gpat_n;
    ghist_o           = shift_hist(ghist_i, item_i.taken);
  end

  // Row value after reset
  always_comb begin
    for (int i = 0; i < HistPatterns; i++) begin
      pat_rst[i] = PatternRst;
    end
    rst_row_o             = '0;
    rst_row_o[BimLo +: 2] = BimodalRst;
    rst_row_o[ChoLo +: 2] = ChooserRst;
    rst_row_o[LpLo +: PW] = pat_rst;
    rst_row_o[GpLo +: PW] = pat_rst;
  end

endmodule

`default_nettype wire

// ===== rtl/hybrid_branch_predictor.sv =====
// Top level of the tournament branch predictor: request pipeline, entry RAM,
// write forwarding and output register. Uses bhp_pkg, bhp_index, bhp_ram,
// bhp_row_logic.
//
//   Channel   Dir  tdata                                   tuser
//   s_axis    in   pc[31:0] taken[32] hit[33] target[65:34] req_type
//   m_axis    out  next_pc[31:0]                            chosen_source
//   cfg       in   training_limit on cfg_wdata_i, written when cfg_we_i
//
// One beat per cycle is taken while s_axis_tready is high; a predict beat
// goes through the input stage, the two index stages, the RAM read and
// update stage and the output register before it shows on m_axis.
// Update beats give no output and never wait on m_axis. After reset a
// clearing pass writes every entry row while s_axis_tready stays low.
// A held output stalls only a predict beat in the update stage, and the
// stages behind it fill up.
`default_nettype none

module hybrid_branch_predictor import bhp_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES    = TableEntriesDef,
  parameter int unsigned HISTORY_PATTERNS = HistPatternsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [3:0]          cfg_wdata_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // pc[31:0], taken[32], hit[33], target[65:34], zero pad [71:66]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // req_type[0]
  input  wire logic                s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // next_pc[31:0]
  output logic      [OutDataW-1:0] m_axis_tdata,
  // chosen_source[1:0]
  output logic      [1:0]          m_axis_tuser
);

  localparam int unsigned AW   = $clog2(TABLE_ENTRIES);
  localparam int unsigned HB   = $clog2(HISTORY_PATTERNS);
  localparam int unsigned RowW = row_width(HISTORY_PATTERNS);

  item_t           in_item, a_item_q, b_item_q, c_item_q, d_item_q;
  logic            a_valid_q, b_valid_q, c_valid_q, d_valid_q, out_valid_q;
  logic            a_valid_d, b_valid_d, c_valid_d, d_valid_d, out_valid_d;
  logic            a_go, b_go, c_go, d_go, a_free, b_free, c_free, d_free;
  logic            out_free, in_acc, d_upd;
  pred_t           out_q, pred;
  logic            clearing_q, clearing_d;
  logic [AW-1:0]   clr_addr_q, clr_addr_d;
  logic [3:0]      limit_q;
  logic [HB-1:0]   ghist_q, ghist_new;
  logic [AW-1:0]   id_c, d_id_q;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [RowW-1:0] wr_data, ram_rdata, row_cur, row_new, rst_row, fwd_row_q;
  logic            fwd_hit_q;

  // Unpack the request beat
  always_comb begin
    in_item.req    = req_e'(s_axis_tuser);
    in_item.pc     = s_axis_tdata[31:0];
    in_item.taken  = s_axis_tdata[32];
    in_item.hit    = s_axis_tdata[33];
    in_item.target = s_axis_tdata[65:34];
  end

  // Stage flow: advance when the next stage is free
  always_comb begin
    out_free      = !out_valid_q || m_axis_tready;
    d_upd         = d_item_q.req == REQ_UPDATE;
    d_go          = d_valid_q && (d_upd || out_free);
    d_free        = !d_valid_q || d_go;
    c_go          = c_valid_q && d_free;
    c_free        = !c_valid_q || c_go;
    b_go          = b_valid_q && c_free;
    b_free        = !b_valid_q || b_go;
    a_go          = a_valid_q && b_free;
    a_free        = !a_valid_q || a_go;
    s_axis_tready = a_free && !clearing_q;
    in_acc        = s_axis_tvalid && s_axis_tready;
  end

  always_comb begin
    a_valid_d   = in_acc || (a_valid_q && !a_go);
    b_valid_d   = a_go || (b_valid_q && !b_go);
    c_valid_d   = b_go || (c_valid_q && !c_go);
    d_valid_d   = c_go || (d_valid_q && !d_go);
    out_valid_d = (d_go && !d_upd) || (out_valid_q && !m_axis_tready);
  end

  // Clearing pass over all entry rows after reset
  always_comb begin
    clr_addr_d = clr_addr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(TABLE_ENTRIES - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      clearing_q  <= 1'b1;
      clr_addr_q  <= '0;
      limit_q     <= TrainLimitRst;
      ghist_q     <= '0;
      fwd_hit_q   <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      b_valid_q   <= b_valid_d;
      c_valid_q   <= c_valid_d;
      d_valid_q   <= d_valid_d;
      out_valid_q <= out_valid_d;
      clearing_q  <= clearing_d;
      clr_addr_q  <= clr_addr_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (d_go && d_upd) begin
        ghist_q <= ghist_new;
      end
      // Catch a row written at the edge of its own read
      if (c_go) begin
        fwd_hit_q <= wr_en && (wr_addr == id_c);
      end
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_item_q <= in_item;
    end
    if (a_go) begin
      b_item_q <= a_item_q;
    end
    if (b_go) begin
      c_item_q <= b_item_q;
    end
    if (c_go) begin
      d_item_q  <= c_item_q;
      d_id_q    <= id_c;
      fwd_row_q <= wr_data;
    end
    if (d_go && !d_upd) begin
      out_q <= pred;
    end
  end

  // Entry index
  bhp_index #(
    .TableEntries(TABLE_ENTRIES)
  ) u_bhp_index (
    .clk_i (clk_i),
    .x_i   (a_item_q.pc[31:2]),
    .b_en_i(a_go),
    .c_en_i(b_go),
    .id_o  (id_c)
  );

  // Row write: clearing pass or update
  always_comb begin
    if (clearing_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
      wr_data = rst_row;
    end else begin
      wr_en   = d_go && d_upd;
      wr_addr = d_id_q;
      wr_data = row_new;
    end
  end

  bhp_ram #(
    .Width(RowW),
    .Depth(TABLE_ENTRIES)
  ) u_bhp_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (c_go),
    .raddr_i(id_c),
    .rdata_o(ram_rdata)
  );

  assign row_cur = fwd_hit_q ? fwd_row_q : ram_rdata;

  bhp_row_logic #(
    .HistPatterns(HISTORY_PATTERNS)
  ) u_bhp_row_logic (
    .row_i    (row_cur),
    .item_i   (d_item_q),
    .ghist_i  (ghist_q),
    .limit_i  (limit_q),
    .row_o    (row_new),
    .ghist_o  (ghist_new),
    .pred_o   (pred),
    .rst_row_o(rst_row)
  );

  // Result beat
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.next_pc;
  assign m_axis_tuser  = out_q.src;

endmodule

`default_nettype wire

// ===== rtl/bhp_checker.sv =====
// Port-level checks for the hybrid branch predictor, bound to the top level.
// No dependencies beyond the top level's ports.
`default_nettype none

module bhp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // A stalled result beat stays and holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // Clearing pass blocks requests, and no result shows before one can pass
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready ##1 !s_axis_tready
      ##1 !m_axis_tvalid ##1 !m_axis_tvalid ##1 !m_axis_tvalid
      ##1 !m_axis_tvalid ##1 !m_axis_tvalid)
    else $error("activity during clearing pass");

  // With the output register empty nothing can block the request side
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && $past(s_axis_tready) |-> s_axis_tready)
    else $error("request side blocked with empty output");

endmodule

bind hybrid_branch_predictor bhp_checker u_bhp_checker (.*);

`default_nettype wire
